// File: hw/rtl/rc4pf_pkg.sv
// ---------------------------------------------------------------------------
// rc4pf_pkg
// Shared widths, defaults and register indexes for the RC4 plaintext-feedback
// cipher.
// ---------------------------------------------------------------------------
package rc4pf_pkg;

  localparam int DATA_W            = 8;
  localparam int TBL_DEPTH         = 256;
  localparam int ADDR_W            = 8;
  localparam int KEY_W             = 64;
  localparam int KLEN_W            = 4;
  localparam int CFG_IDX_W         = 1;
  localparam int MAX_KEY_BYTES_DEF = 8;

  localparam logic [KLEN_W-1:0] KEY_LEN_RST = 4'd6;
  localparam logic [ADDR_W-1:0] ADDR_LAST   = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_BYTES  = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } cfg_reg_t;

endpackage

// File: hw/rtl/rc4pf_ram.sv
// ---------------------------------------------------------------------------
// rc4pf_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ---------------------------------------------------------------------------
module rc4pf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rc4_plaintext_feedback_cipher.sv
// ---------------------------------------------------------------------------
// rc4_plaintext_feedback_cipher
// RC4 variant whose first index advances by one plus the plaintext byte.
// ---------------------------------------------------------------------------
// One byte is taken at a time; the block stalls its input until the result is
// in the output register. The next byte can be accepted in the cycle the
// result appears. The steps of a byte run one after another, as the
// permutation RAM has a single read port: two dependent reads, two swap
// writes and the keystream read. A byte flagged as start of message, and
// the first byte after reset, first runs the key schedule: it loads the
// identity into all 256 entries, then does a keyed swap for each entry
// (two reads, then two writes). The key registers are read only during the
// schedule. The result register holds while it is valid and out_stall is
// high.
// ---------------------------------------------------------------------------
module rc4_plaintext_feedback_cipher
  import rc4pf_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_data_byte,
  input  logic                 in_start_of_message,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_cipher_byte
);

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KLEN_W-1:0] MAX_LEN = KLEN_W'(MAX_KEY_BYTES);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_KS_INIT = 11'b000_0000_0010,
    ST_KS_RD_N = 11'b000_0000_0100,
    ST_KS_RD_J = 11'b000_0000_1000,
    ST_KS_WR_N = 11'b000_0001_0000,
    ST_KS_WR_J = 11'b000_0010_0000,
    ST_B_RD_I  = 11'b000_0100_0000,
    ST_B_RD_J  = 11'b000_1000_0000,
    ST_B_WR_I  = 11'b001_0000_0000,
    ST_B_WR_J  = 11'b010_0000_0000,
    ST_B_KS    = 11'b100_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [KEY_W-1:0]   key_bytes_r;
  logic [KLEN_W-1:0]  key_length_r;
  logic               keyed_r, keyed_nxt;
  logic [ADDR_W-1:0]  idx_i_r, idx_i_nxt;
  logic [ADDR_W-1:0]  idx_j_r, idx_j_nxt;
  logic [ADDR_W-1:0]  n_r, n_nxt;
  logic [ADDR_W-1:0]  j_r, j_nxt;
  logic [KIDX_W-1:0]  kidx_r, kidx_nxt;
  logic [DATA_W-1:0]  data_r, data_nxt;
  logic [DATA_W-1:0]  si_r, si_nxt;
  logic [DATA_W-1:0]  sj_r, sj_nxt;
  logic [ADDR_W-1:0]  k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_byte_r, out_byte_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic [KLEN_W-1:0]  eff_len;
  logic [DATA_W-1:0]  key_byte;
  logic               kidx_last;
  logic [ADDR_W-1:0]  i_new;
  logic [ADDR_W-1:0]  j_new;
  logic [DATA_W-1:0]  ks;

  rc4pf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TBL_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cipher_byte = out_byte_r;

  always_comb begin
    if (key_length_r == '0) begin
      eff_len = KLEN_W'(1);
    end else if (key_length_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_length_r;
    end
  end

  assign key_byte  = key_bytes_r[8*kidx_r +: 8];
  assign kidx_last = (KLEN_W'(kidx_r) == (eff_len - KLEN_W'(1)));
  assign ks        = (k_r == idx_j_r) ? si_r : ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= '0;
      key_length_r <= KEY_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_BYTES:  key_bytes_r  <= cfg_wdata;
        REG_KEY_LENGTH: key_length_r <= cfg_wdata[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    keyed_nxt     = keyed_r;
    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    kidx_nxt      = kidx_r;
    data_nxt      = data_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    ram_we        = 1'b0;
    ram_waddr     = n_r;
    ram_wdata     = n_r;
    ram_raddr     = n_r;
    i_new         = idx_i_r + 8'd1 + data_r;
    j_new         = idx_j_r + ram_rdata;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        i_new = idx_i_r + 8'd1 + in_data_byte;
        if (in_valid) begin
          data_nxt = in_data_byte;
          if (in_start_of_message || !keyed_r) begin
            n_nxt     = '0;
            state_nxt = ST_KS_INIT;
          end else begin
            idx_i_nxt = i_new;
            ram_raddr = i_new;
            state_nxt = ST_B_RD_J;
          end
        end
      end
      ST_KS_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = n_r;
        ram_wdata = n_r;
        n_nxt     = n_r + 8'd1;
        if (n_r == ADDR_LAST) begin
          j_nxt     = '0;
          kidx_nxt  = '0;
          state_nxt = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        ram_raddr = n_r;
        state_nxt = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        j_new     = j_r + ram_rdata + key_byte;
        si_nxt    = ram_rdata;
        j_nxt     = j_new;
        ram_raddr = j_new;
        kidx_nxt  = kidx_last ? '0 : kidx_r + KIDX_W'(1);
        state_nxt = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        ram_we    = 1'b1;
        ram_waddr = n_r;
        ram_wdata = ram_rdata;
        state_nxt = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = si_r;
        n_nxt     = n_r + 8'd1;
        if (n_r == ADDR_LAST) begin
          keyed_nxt = 1'b1;
          idx_i_nxt = '0;
          idx_j_nxt = '0;
          state_nxt = ST_B_RD_I;
        end else begin
          state_nxt = ST_KS_RD_N;
        end
      end
      ST_B_RD_I: begin
        idx_i_nxt = i_new;
        ram_raddr = i_new;
        state_nxt = ST_B_RD_J;
      end
      ST_B_RD_J: begin
        si_nxt    = ram_rdata;
        idx_j_nxt = j_new;
        ram_raddr = j_new;
        state_nxt = ST_B_WR_I;
      end
      ST_B_WR_I: begin
        sj_nxt    = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = idx_i_r;
        ram_wdata = ram_rdata;
        state_nxt = ST_B_WR_J;
      end
      ST_B_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = idx_j_r;
        ram_wdata = si_r;
        k_nxt     = si_r + sj_r;
        ram_raddr = si_r + sj_r;
        state_nxt = ST_B_KS;
      end
      ST_B_KS: begin
        // same-edge write at j is not yet visible to the read
        ram_raddr = k_r;
        if (!out_valid_r || !out_stall) begin
          out_byte_nxt  = data_r ^ ks;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keyed_r     <= 1'b0;
      idx_i_r     <= '0;
      idx_j_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      keyed_r     <= keyed_nxt;
      idx_i_r     <= idx_i_nxt;
      idx_j_r     <= idx_j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    kidx_r     <= kidx_nxt;
    data_r     <= data_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    k_r        <= k_nxt;
    out_byte_r <= out_byte_nxt;
  end

  a_keyed_after_sched: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(keyed_r) |-> $past(state_r == ST_KS_WR_J))
    else $error("keyed set outside end of key schedule");

  a_out_from_ks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_B_KS))
    else $error("result loaded outside keystream step");

  a_start_runs_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_start_of_message) |=> (state_r == ST_KS_INIT))
    else $error("start of message did not start key schedule");

  a_ks_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_B_KS && out_valid_r && out_stall) |=> (state_r == ST_B_KS))
    else $error("result overwritten while output stalled");

endmodule
